[rtl/core/kmhr_pkg.sv]
// kmhr_pkg: sizes, code points and the two layout tables of the keyboard report core
// depends on nothing; imported by keyboard_matrix_hid_report_core and tb_top
package kmhr_pkg;

    localparam int ROWS    = 5;
    localparam int COLUMNS = 13;
    localparam int SLOTS   = 6;

    localparam int OUT_SLOTS = 6;
    localparam int ROM_ROWS  = 5;
    localparam int ROM_COLS  = 13;

    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [7:0] CODE_NONE    = 8'h00;
    localparam logic [7:0] CODE_MOD_LO  = 8'hE0;
    localparam logic [7:0] CODE_MOD_HI  = 8'hE7;
    localparam logic [7:0] CODE_TOGGLE  = 8'hFF;

    localparam logic [3:0] POS_HIGH_LAST  = 4'd7;
    localparam logic [3:0] POS_LOW_FIRST  = 4'd11;
    localparam logic [3:0] COL_HIGH_FIRST = 4'd5;

    typedef logic [COLUMNS-1:0] t_row_bits;

    typedef struct packed {
        t_row_bits prev;
        t_row_bits now;
    } t_row_word;

    typedef logic [7:0] t_code;

    localparam t_code LAYOUT_A [ROM_ROWS*ROM_COLS] = '{
        8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E,
        8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30,
        8'h39, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h31,
        8'hE1, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'hE5, 8'h35,
        8'hE3, 8'hFE, 8'hFF, 8'hE2, 8'h2A, 8'h28, 8'h2C, 8'h8A, 8'hE4, 8'h50, 8'h51, 8'h52, 8'h4F
    };

    localparam t_code LAYOUT_B [ROM_ROWS*ROM_COLS] = '{
        8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2F, 8'h30,
        8'h2B, 8'h34, 8'h36, 8'h12, 8'h18, 8'h1C, 8'h09, 8'h0A, 8'h06, 8'h15, 8'h0F, 8'h38, 8'h2E,
        8'hE0, 8'h13, 8'h0C, 8'h08, 8'h04, 8'h37, 8'h07, 8'h16, 8'h17, 8'h0B, 8'h1D, 8'h2D, 8'h31,
        8'hE1, 8'h0D, 8'h14, 8'h33, 8'h0E, 8'h1B, 8'h05, 8'h10, 8'h1A, 8'h11, 8'h19, 8'hE5, 8'h35,
        8'hE3, 8'hFE, 8'hFF, 8'hE2, 8'h2A, 8'h4C, 8'h28, 8'h2C, 8'h39, 8'h50, 8'h51, 8'h52, 8'h4F
    };

    // key code at a matrix position, none outside the tables
    function automatic t_code rom_code(input logic sel, input logic [4:0] row,
                                       input logic [4:0] col);
        logic [6:0] idx;
        idx = 7'(row) * 7'(ROM_COLS) + 7'(col);
        if (row >= 5'(ROM_ROWS) || col >= 5'(ROM_COLS)) begin
            return CODE_NONE;
        end
        return sel ? LAYOUT_B[idx] : LAYOUT_A[idx];
    endfunction

endpackage

[rtl/core/keyboard_matrix_hid_report_core.sv]
// keyboard_matrix_hid_report_core: switch samples in, six-key boot keyboard reports out
// depends on kmhr_pkg (sizes, codes, layout tables)
//
//  channel  | handshake           | word
//  ---------+---------------------+------------------------------------------------
//  input    | i_valid / o_ready   | i_mode i_row i_bit_pos i_pressed i_host_ready
//  output   | o_valid / i_ready   | o_modifier_bits o_slot_0..o_slot_5 o_layout_sel
//
// one word per cycle unless stage 1 stalls: the row state ram is read on acceptance and
// written back in the next cycle; a sample that hits the row just written is fed from
// the bypass; end of scan is decided combinationally from per-row due flags; row_before
// is committed for every row at once through per-row sync bits, so no copy sweep is needed
// reset clears all control flops at once; row entries read as zero until first written
// an end of scan with a report waits in stage 1 while a full output register is not taken

module keyboard_matrix_hid_report_core
    import kmhr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_mode,
    input  logic [2:0] i_row,
    input  logic [3:0] i_bit_pos,
    input  logic       i_pressed,
    input  logic       i_host_ready,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_modifier_bits,
    output logic [7:0] o_slot_0,
    output logic [7:0] o_slot_1,
    output logic [7:0] o_slot_2,
    output logic [7:0] o_slot_3,
    output logic [7:0] o_slot_4,
    output logic [7:0] o_slot_5,
    output logic       o_layout_sel
);

    // row state ram
    t_row_word r_mem [ROWS];
    t_row_word r_rd;

    // stage 1
    logic              r_s1_valid;
    logic              r_s1_mode;
    logic              r_s1_hit;
    logic [ROW_AW-1:0] r_s1_row;
    logic [3:0]        r_s1_col;
    logic              r_s1_pressed;
    logic              r_s1_host_ready;
    logic              r_fwd;
    t_row_word         r_fwd_word;

    // per-row flags
    logic [ROWS-1:0] r_vld;
    logic [ROWS-1:0] r_sync;
    logic [ROWS-1:0] r_due;
    logic [ROWS-1:0] r_nz;

    // key state
    t_code       r_slots [SLOTS];
    logic [7:0]  r_modifier;
    logic        r_layout;
    logic        r_toggle_latch;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_out_mod;
    t_code       r_out_slots [OUT_SLOTS];
    logic        r_out_layout;

    logic              in_acc;
    logic              in_hit;
    logic [3:0]        in_col;
    logic [ROW_AW-1:0] in_raddr;
    logic              s1_adv;
    logic              s1_stall;
    logic              s1_sample;
    logic              s1_eos;
    logic              wr_en;
    t_row_word         cur_word;
    t_row_bits         cur_before;
    t_row_bits         new_now;
    t_row_bits         col_bit;
    t_code             code;
    logic              apply;
    logic              is_mod;
    logic              due_any;
    logic              emit;
    logic              commit;
    t_code             n_slots [SLOTS];
    logic [7:0]        n_modifier;
    logic              n_layout;
    logic              n_toggle_latch;
    logic              placed;
    t_code             out_slots [OUT_SLOTS];

    // column decode of the shift chain position
    always_comb begin
        in_col = 4'd0;
        in_hit = 1'b0;
        if (i_bit_pos <= POS_HIGH_LAST) begin
            in_col = i_bit_pos + COL_HIGH_FIRST;
            in_hit = 1'b1;
        end else if (i_bit_pos >= POS_LOW_FIRST) begin
            in_col = i_bit_pos - POS_LOW_FIRST;
            in_hit = 1'b1;
        end
        if ({1'b0, i_row} >= 4'(ROWS) || {1'b0, in_col} >= 5'(COLUMNS)) begin
            in_hit = 1'b0;
        end
        in_raddr = ROW_AW'(i_row);
    end

    assign s1_sample = r_s1_valid && !r_s1_mode;
    assign s1_eos    = r_s1_valid && r_s1_mode;
    assign due_any   = |r_due;
    assign emit      = s1_eos && due_any && r_s1_host_ready;
    assign commit    = s1_eos && (!due_any || r_s1_host_ready);
    assign s1_stall  = emit && r_out_valid && !i_ready;
    assign s1_adv    = r_s1_valid && !s1_stall;
    assign o_ready   = !r_s1_valid || s1_adv;
    assign in_acc    = i_valid && o_ready;

    // read-modify-write of the row word
    always_comb begin
        if (r_fwd) begin
            cur_word = r_fwd_word;
        end else if (r_vld[r_s1_row]) begin
            cur_word = r_rd;
        end else begin
            cur_word = '0;
        end
        // after a commit the stored now value is also the previous scan
        cur_before = r_sync[r_s1_row] ? cur_word.now : cur_word.prev;
        col_bit    = t_row_bits'(1) << r_s1_col;
        new_now    = r_s1_pressed ? (cur_word.now | col_bit) : (cur_word.now & ~col_bit);
        wr_en      = s1_sample && r_s1_hit;
        code       = rom_code(r_layout, 5'(r_s1_row), 5'(4'(COLUMNS - 1) - r_s1_col));
        apply      = r_s1_pressed || (new_now != cur_before);
        is_mod     = (code >= CODE_MOD_LO) && (code <= CODE_MOD_HI);
    end

    // key code update
    always_comb begin
        n_slots        = r_slots;
        n_modifier     = r_modifier;
        n_layout       = r_layout;
        n_toggle_latch = r_toggle_latch;
        placed         = 1'b0;
        if (wr_en && apply) begin
            if (code == CODE_TOGGLE) begin
                if (r_s1_pressed) begin
                    if (!r_toggle_latch) begin
                        n_layout = ~r_layout;
                    end
                    n_toggle_latch = 1'b1;
                end else begin
                    n_toggle_latch = 1'b0;
                end
            end else if (is_mod) begin
                n_modifier[code[2:0]] = r_s1_pressed;
            end else if (r_s1_pressed) begin
                // first slot holding the code or empty, whichever comes first
                for (int k = 0; k < SLOTS; k++) begin
                    if (!placed && r_slots[k] == code) begin
                        placed = 1'b1;
                    end else if (!placed && r_slots[k] == CODE_NONE) begin
                        n_slots[k] = code;
                        placed     = 1'b1;
                    end
                end
            end else begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (r_slots[k] == code) begin
                        n_slots[k] = CODE_NONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_hit) begin
            r_rd <= r_mem[in_raddr];
        end
        if (wr_en) begin
            r_mem[r_s1_row] <= '{prev: cur_before, now: new_now};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_fwd          <= 1'b0;
            r_vld          <= '0;
            r_sync         <= '0;
            r_due          <= '0;
            r_nz           <= '0;
            r_modifier     <= '0;
            r_layout       <= 1'b0;
            r_toggle_latch <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_slots[k] <= CODE_NONE;
            end
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                // bypass only for a sample that will touch the row being written
                r_fwd      <= wr_en && !i_mode && in_hit && (r_s1_row == in_raddr);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
                r_fwd      <= 1'b0;
            end
            if (wr_en) begin
                r_vld[r_s1_row]  <= 1'b1;
                r_sync[r_s1_row] <= 1'b0;
                r_nz[r_s1_row]   <= |new_now;
                r_due[r_s1_row]  <= (|new_now) || (new_now != cur_before);
            end
            if (commit && s1_adv) begin
                r_sync <= '1;
                r_due  <= r_nz;
            end
            r_slots        <= n_slots;
            r_modifier     <= n_modifier;
            r_layout       <= n_layout;
            r_toggle_latch <= n_toggle_latch;
            if (emit && s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < OUT_SLOTS; k++) begin
            out_slots[k] = CODE_NONE;
            if (k < SLOTS) begin
                out_slots[k] = r_slots[k];
            end
        end
    end

    // stage 1 payload and report payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_mode       <= i_mode;
            r_s1_hit        <= in_hit;
            r_s1_row        <= in_raddr;
            r_s1_col        <= in_col;
            r_s1_pressed    <= i_pressed;
            r_s1_host_ready <= i_host_ready;
            r_fwd_word      <= '{prev: cur_before, now: new_now};
        end
        if (emit && s1_adv) begin
            r_out_mod    <= r_modifier;
            r_out_slots  <= out_slots;
            r_out_layout <= r_layout;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_modifier_bits = r_out_mod;
    assign o_slot_0        = r_out_slots[0];
    assign o_slot_1        = r_out_slots[1];
    assign o_slot_2        = r_out_slots[2];
    assign o_slot_3        = r_out_slots[3];
    assign o_slot_4        = r_out_slots[4];
    assign o_slot_5        = r_out_slots[5];
    assign o_layout_sel    = r_out_layout;

`ifndef NO_ASSERTIONS
    // a stalled end of scan blocks new words
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_stall |-> !in_acc)
        else $error("word accepted while stage 1 is stalled");

    // bypass only ever serves a sample sitting in stage 1
    a_fwd_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> (r_s1_valid && !r_s1_mode))
        else $error("bypass active without a sample in stage 1");

    // a synced row is due exactly when it is nonzero
    a_sync_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_due & r_sync) == (r_nz & r_sync)))
        else $error("due flag out of step with a synced row");

    // a new report needs a ready host at end of scan
    a_report_host: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && s1_adv) |-> (r_s1_host_ready && r_s1_mode))
        else $error("report loaded without a ready host");

    // a row can only be due once it has been written since reset
    a_due_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_due & ~r_vld) == '0))
        else $error("due flag set on an unwritten row");
`endif

endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for keyboard_matrix_hid_report_core, driver and monitor
// as clocked blocks with a local predictor of the key slots and report words
// depends on kmhr_pkg and keyboard_matrix_hid_report_core
`timescale 1ns / 100ps

module tb_top;
    import kmhr_pkg::*;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_EOS    = 1'b1;
    localparam int   LIVE_WORDS  = 1400;
    localparam int   TAIL_WORDS  = 150;
    localparam int   STALL_LIMIT = 2000;
    localparam int   DRAIN_WAIT  = 30;

    // keymaps, row-major, indexed by reversed column
    localparam logic [7:0] KEYMAP_A [0:64] = '{
        8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E,
        8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C, 8'h12, 8'h13, 8'h2F, 8'h30,
        8'h39, 8'h04, 8'h16, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33, 8'h34, 8'h31,
        8'hE1, 8'h1D, 8'h1B, 8'h06, 8'h19, 8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'hE5, 8'h35,
        8'hE3, 8'hFE, 8'hFF, 8'hE2, 8'h2A, 8'h28, 8'h2C, 8'h8A, 8'hE4, 8'h50, 8'h51, 8'h52, 8'h4F
    };
    localparam logic [7:0] KEYMAP_B [0:64] = '{
        8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2F, 8'h30,
        8'h2B, 8'h34, 8'h36, 8'h12, 8'h18, 8'h1C, 8'h09, 8'h0A, 8'h06, 8'h15, 8'h0F, 8'h38, 8'h2E,
        8'hE0, 8'h13, 8'h0C, 8'h08, 8'h04, 8'h37, 8'h07, 8'h16, 8'h17, 8'h0B, 8'h1D, 8'h2D, 8'h31,
        8'hE1, 8'h0D, 8'h14, 8'h33, 8'h0E, 8'h1B, 8'h05, 8'h10, 8'h1A, 8'h11, 8'h19, 8'hE5, 8'h35,
        8'hE3, 8'hFE, 8'hFF, 8'hE2, 8'h2A, 8'h4C, 8'h28, 8'h2C, 8'h39, 8'h50, 8'h51, 8'h52, 8'h4F
    };

    typedef struct packed {
        logic       mode;
        logic [2:0] row;
        logic [3:0] pos;
        logic       pressed;
        logic       host_ready;
    } scan_word_t;

    typedef struct packed {
        logic [7:0]      mods;
        logic [5:0][7:0] slots;
        logic            layout;
    } hid_report_t;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       i_mode       = 1'b0;
    logic [2:0] i_row        = '0;
    logic [3:0] i_bit_pos    = '0;
    logic       i_pressed    = 1'b0;
    logic       i_host_ready = 1'b0;
    logic       i_ready      = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_modifier_bits;
    logic [7:0] o_slot_0, o_slot_1, o_slot_2, o_slot_3, o_slot_4, o_slot_5;
    logic       o_layout_sel;

    keyboard_matrix_hid_report_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_row           (i_row),
        .i_bit_pos       (i_bit_pos),
        .i_pressed       (i_pressed),
        .i_host_ready    (i_host_ready),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_modifier_bits (o_modifier_bits),
        .o_slot_0        (o_slot_0),
        .o_slot_1        (o_slot_1),
        .o_slot_2        (o_slot_2),
        .o_slot_3        (o_slot_3),
        .o_slot_4        (o_slot_4),
        .o_slot_5        (o_slot_5),
        .o_layout_sel    (o_layout_sel)
    );

    always #6 i_clk = ~i_clk;

    // predicted keyboard state
    logic [7:0]         kb_slots  [SLOTS];
    logic [7:0]         kb_mods   = '0;
    logic [COLUMNS-1:0] kb_now    [ROWS];
    logic [COLUMNS-1:0] kb_before [ROWS];
    logic               kb_layout = 1'b0;
    logic               kb_latch  = 1'b0;

    scan_word_t  word_q [$];
    hid_report_t report_q [$];
    scan_word_t  cur_word;
    scan_word_t  next_word;
    logic [COLUMNS-1:0] held [ROWS];
    int live_cnt     = 0;
    int mismatch_cnt = 0;
    int send_gap     = 0;
    int hold_cnt     = 0;
    int idle_cycles  = 0;

    initial begin
        for (int k = 0; k < SLOTS; k++) kb_slots[k] = '0;
        for (int r = 0; r < ROWS; r++) begin
            kb_now[r]    = '0;
            kb_before[r] = '0;
            held[r]      = '0;
        end
    end

    task automatic log_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    // advance the predicted state by one accepted word, queue a report if one goes out
    function void track_scan_word(input scan_word_t w);
        int          col;
        int          rc;
        logic [7:0]  code;
        logic        due;
        hid_report_t rep;
        if (w.mode == MODE_SAMPLE) begin
            if (w.row >= ROWS) return;
            if (w.pos <= 4'd7) col = w.pos + 5;
            else if (w.pos >= 4'd11) col = w.pos - 11;
            else return;
            if (col >= COLUMNS) return;
            rc = COLUMNS - 1 - col;
            if (w.row < 5 && rc < 13)
                code = kb_layout ? KEYMAP_B[w.row * 13 + rc] : KEYMAP_A[w.row * 13 + rc];
            else
                code = CODE_NONE;
            if (w.pressed) begin
                kb_now[w.row][col] = 1'b1;
                if (code == CODE_TOGGLE) begin
                    if (!kb_latch) begin
                        kb_layout = ~kb_layout;
                        kb_latch  = 1'b1;
                    end
                end else if (code >= CODE_MOD_LO && code <= CODE_MOD_HI) begin
                    kb_mods[code - CODE_MOD_LO] = 1'b1;
                end else begin
                    for (int k = 0; k < SLOTS; k++) begin
                        if (kb_slots[k] == code) break;
                        if (kb_slots[k] == CODE_NONE) begin
                            kb_slots[k] = code;
                            break;
                        end
                    end
                end
            end else begin
                kb_now[w.row][col] = 1'b0;
                // release only counts when the row moved since the last committed scan
                if (kb_now[w.row] != kb_before[w.row]) begin
                    if (code == CODE_TOGGLE) begin
                        kb_latch = 1'b0;
                    end else if (code >= CODE_MOD_LO && code <= CODE_MOD_HI) begin
                        kb_mods[code - CODE_MOD_LO] = 1'b0;
                    end else begin
                        for (int k = 0; k < SLOTS; k++)
                            if (kb_slots[k] == code) kb_slots[k] = CODE_NONE;
                    end
                end
            end
        end else begin
            due = 1'b0;
            for (int r = 0; r < ROWS; r++)
                if (kb_now[r] != '0 || kb_now[r] != kb_before[r]) due = 1'b1;
            // host busy: drop the report and keep the old row states
            if (due && !w.host_ready) return;
            if (due) begin
                rep.mods = kb_mods;
                for (int k = 0; k < 6; k++) rep.slots[k] = (k < SLOTS) ? kb_slots[k] : '0;
                rep.layout = kb_layout;
                report_q.push_back(rep);
            end
            for (int r = 0; r < ROWS; r++) kb_before[r] = kb_now[r];
        end
    endfunction

    task automatic check_report();
        hid_report_t     exp;
        logic [5:0][7:0] got;
        got = {o_slot_5, o_slot_4, o_slot_3, o_slot_2, o_slot_1, o_slot_0};
        if (report_q.size() == 0) begin
            log_mismatch("report word with none expected");
        end else begin
            exp = report_q.pop_front();
            if (o_modifier_bits !== exp.mods)
                log_mismatch($sformatf("modifier_bits got %02h exp %02h",
                                       o_modifier_bits, exp.mods));
            for (int k = 0; k < 6; k++)
                if (got[k] !== exp.slots[k])
                    log_mismatch($sformatf("slot_%0d got %02h exp %02h",
                                           k, got[k], exp.slots[k]));
            if (o_layout_sel !== exp.layout)
                log_mismatch($sformatf("layout_sel got %b exp %b", o_layout_sel, exp.layout));
        end
    endtask

    task automatic add_word(input logic m, input logic [2:0] r, input logic [3:0] p,
                            input logic pr, input logic hr);
        scan_word_t w;
        w = '{mode: m, row: r, pos: p, pressed: pr, host_ready: hr};
        word_q.push_back(w);
        if (!(m == MODE_SAMPLE && (r >= ROWS || (p >= 4'd8 && p <= 4'd10)))) live_cnt++;
    endtask

    // switch at a matrix column, mapped back to its shift-chain position
    task automatic add_key(input int r, input int c, input logic pr);
        held[r][c] = pr;
        add_word(MODE_SAMPLE, 3'(r), (c < 5) ? 4'(c + 11) : 4'(c - 5), pr,
                 1'($urandom_range(0, 1)));
    endtask

    task automatic add_eos(input logic hr);
        add_word(MODE_EOS, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                 1'($urandom_range(0, 1)), hr);
    endtask

    function automatic int held_total();
        int n;
        n = 0;
        for (int r = 0; r < ROWS; r++) n += $countones(held[r]);
        return n;
    endfunction

    // driver: one word in flight, random gaps between words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) track_scan_word(cur_word);
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (word_q.size() > 0) begin
                    next_word = word_q.pop_front();
                    cur_word     <= next_word;
                    i_mode       <= next_word.mode;
                    i_row        <= next_word.row;
                    i_bit_pos    <= next_word.pos;
                    i_pressed    <= next_word.pressed;
                    i_host_ready <= next_word.host_ready;
                    i_valid      <= 1'b1;
                    if (word_q.size() > TAIL_WORDS && $urandom_range(0, 11) == 0)
                        send_gap <= $urandom_range(1, 18);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each report word, stalls the output at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) check_report();
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_ready  <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (word_q.size() > TAIL_WORDS && $urandom_range(0, 11) == 0)
                    hold_cnt <= $urandom_range(1, 18);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int r, c, n;
        // empty matrix: scan end with nothing due
        add_eos(1'b1);
        // rows past the matrix and the unused chain positions
        add_word(MODE_SAMPLE, 3'd7, 4'd0, 1'b1, 1'b0);
        add_word(MODE_SAMPLE, 3'd5, 4'd15, 1'b1, 1'b1);
        add_word(MODE_SAMPLE, 3'd0, 4'd8, 1'b1, 1'b0);
        add_word(MODE_SAMPLE, 3'd1, 4'd9, 1'b1, 1'b1);
        add_word(MODE_SAMPLE, 3'd2, 4'd10, 1'b1, 1'b0);
        // layout toggle, then modifiers from the second layout
        add_key(4, 10, 1'b1);
        add_key(2, 12, 1'b1);
        add_key(3, 12, 1'b1);
        add_eos(1'b0);
        add_eos(1'b1);
        add_key(4, 10, 1'b0);
        add_key(4, 10, 1'b1);
        // eight keys into six slots, plus a repeat of the first
        for (int k = 12; k >= 5; k--) add_key(0, k, 1'b1);
        add_key(0, 12, 1'b1);
        add_eos(1'b1);
        add_key(0, 12, 1'b0);
        add_key(4, 4, 1'b1);
        add_key(4, 0, 1'b1);
        add_eos(1'b1);

        while (live_cnt < LIVE_WORDS) begin
            n = $urandom_range(0, 39);
            if (n == 0) begin
                // let go of everything, then two scans so the quiet path is hit
                for (r = 0; r < ROWS; r++)
                    for (c = 0; c < COLUMNS; c++)
                        if (held[r][c]) add_key(r, c, 1'b0);
                add_eos(1'b1);
                add_eos(1'b1);
            end else if (n < 34) begin
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(0, ROWS - 1);
                    c = $urandom_range(0, COLUMNS - 1);
                    if (held_total() >= 8) begin
                        while (!held[r][c]) begin
                            r = $urandom_range(0, ROWS - 1);
                            c = $urandom_range(0, COLUMNS - 1);
                        end
                        add_key(r, c, 1'b0);
                    end else if (held[r][c]) begin
                        add_key(r, c, ($urandom_range(0, 9) < 7) ? 1'b0 : 1'b1);
                    end else begin
                        add_key(r, c, ($urandom_range(0, 9) < 8) ? 1'b1 : 1'b0);
                    end
                end
                add_eos(($urandom_range(0, 9) != 0) ? 1'b1 : 1'b0);
            end else begin
                add_word(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                         4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (word_q.size() != 0 || i_valid) @(posedge i_clk);
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (report_q.size() != 0)
            log_mismatch($sformatf("%0d report words never arrived", report_q.size()));
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/kmhr_pkg.sv
rtl/core/keyboard_matrix_hid_report_core.sv
tb/tb_top.sv
